[sv/swbs_pkg.sv]
// ----------------------------------------------------------------------------
// swbs_pkg: shared types and constants of the sync-word block splitter
// Result beat layout, configuration bundle, status and register codes.
// ----------------------------------------------------------------------------
package swbs_pkg;

    // Upper bound on accepted blocks, and the effective cap seen by a 9-bit limit
    localparam int MOST_BLOCKS = 256;
    localparam int LIMIT_CAP   = (MOST_BLOCKS > 511) ? 511 : MOST_BLOCKS;

    // Block counter saturates at limit plus one, limit is at most 511
    localparam int BCNT_W = 10;

    // Sync word length in bytes
    localparam int WIN_BYTES = 8;

    // Result queue geometry
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int LEVEL_W    = 3;

    // Final status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_SIG    = 3'd1;
    localparam logic [2:0] ST_TOO_MANY   = 3'd2;
    localparam logic [2:0] ST_TOO_LONG   = 3'd3;
    localparam logic [2:0] ST_NO_CONTENT = 3'd4;

    // Register index codes (byte address divided by eight)
    localparam logic [1:0] REG_SYNC         = 2'd0;
    localparam logic [1:0] REG_BLOCK_LIMIT  = 2'd1;
    localparam logic [1:0] REG_LENGTH_LIMIT = 2'd2;

    // Register reset values
    localparam logic [63:0] SYNC_RESET   = 64'h1FA6_DEBA_CC13_7D74;
    localparam logic [8:0]  BLIMIT_RESET = 9'd256;
    localparam logic [15:0] LLIMIT_RESET = 16'd65535;

    typedef struct packed {
        logic [63:0] sync_pattern;
        logic [8:0]  block_limit;
        logic [15:0] length_limit;
    } t_cfg;

    typedef struct packed {
        logic        has_block;
        logic [7:0]  block_number;
        logic [31:0] payload_offset;
        logic [31:0] payload_length;
        logic [2:0]  final_status;
        logic        run_end;
    } t_result;

endpackage

[sv/swbs_cell.sv]
// ----------------------------------------------------------------------------
// swbs_cell: one byte cell of the sync window
// Holds one window byte, hands it to the next cell on each shift and
// compares the byte arriving from its neighbor against its sync byte.
// ----------------------------------------------------------------------------
module swbs_cell (
    input  logic       i_clk,
    input  logic       i_shift,
    input  logic [7:0] i_byte,
    input  logic [7:0] i_pattern,
    output logic [7:0] o_byte,
    output logic       o_hit
);

    logic [7:0] r_byte;

    // Advance the byte on each accepted beat
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte = r_byte;

    // Compare the byte this cell will hold after the shift
    assign o_hit = (i_byte == i_pattern);

endmodule

[sv/swbs_window.sv]
// ----------------------------------------------------------------------------
// swbs_window: row of byte cells forming the sliding sync window
// Cell zero takes the incoming byte; each cell passes its byte to the next.
// The window matches when every cell sees its sync byte.
// ----------------------------------------------------------------------------
module swbs_window (
    input  logic        i_clk,
    input  logic        i_shift,
    input  logic [7:0]  i_byte,
    input  logic [63:0] i_pattern,
    output logic        o_match
);

    localparam int NumCells = swbs_pkg::WIN_BYTES;

    logic [7:0]          w_in  [NumCells];
    logic [7:0]          w_out [NumCells];
    logic [NumCells-1:0] w_hit;

    // Build the chain, newest byte in cell zero (least significant sync byte)
    for (genvar k = 0; k < NumCells; k++) begin : g_cell
        if (k == 0) begin : g_head
            assign w_in[k] = i_byte;
        end else begin : g_link
            assign w_in[k] = w_out[k-1];
        end

        swbs_cell u_cell (
            .i_clk     (i_clk),
            .i_shift   (i_shift),
            .i_byte    (w_in[k]),
            .i_pattern (i_pattern[8*k +: 8]),
            .o_byte    (w_out[k]),
            .o_hit     (w_hit[k])
        );
    end

    assign o_match = &w_hit;

endmodule

[sv/swbs_tracker.sv]
// ----------------------------------------------------------------------------
// swbs_tracker: stream position and block bookkeeping
// Tracks the open block, counts blocks, keeps the status flags and forms
// up to two result beats for each accepted byte.
// ----------------------------------------------------------------------------
module swbs_tracker #(
    parameter int POSITION_BITS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic                   i_final,
    input  logic                   i_match,
    input  swbs_pkg::t_cfg         i_cfg,
    output swbs_pkg::t_result      o_res_a,
    output swbs_pkg::t_result      o_res_b,
    output logic [1:0]             o_push_cnt
);

    localparam int PW   = POSITION_BITS;
    localparam int CntW = swbs_pkg::BCNT_W;
    localparam int Cap  = swbs_pkg::LIMIT_CAP;

    logic [PW-1:0]   r_pos;
    logic [PW-1:0]   r_start;
    logic [3:0]      r_since;
    logic            r_open;
    logic [CntW-1:0] r_blocks;
    logic            r_content;
    logic            r_too_long;
    logic            r_sig_bad;

    logic [8:0]      w_lim;
    logic [CntW-1:0] w_lim_x;
    logic [3:0]      w_since_inc;
    logic            w_full;
    logic            w_match;
    logic            w_sig_bad1;
    logic            w_sig_bad2;
    logic [PW-1:0]   w_p1;
    logic [PW-1:0]   w_sync_start;
    logic [PW-1:0]   w_len1;
    logic [PW-1:0]   w_len2;
    logic [PW-1:0]   w_start1;
    logic [PW-1:0]   w_llim;
    logic            w_close1;
    logic            w_emit1;
    logic            w_close2;
    logic            w_emit2;
    logic            w_open1;
    logic [CntW-1:0] w_blocks1;
    logic [CntW-1:0] w_blocks2;
    logic            w_too_long1;
    logic            w_too_long2;
    logic            w_content1;
    logic            w_content2;
    logic [2:0]      w_status;
    swbs_pkg::t_result w_r1;
    swbs_pkg::t_result w_r2;
    swbs_pkg::t_result w_empty;

    // Effective block limit: the smaller of the register and the cap
    assign w_lim   = (i_cfg.block_limit > 9'(Cap)) ? 9'(Cap) : i_cfg.block_limit;
    assign w_lim_x = CntW'(w_lim);
    assign w_llim  = PW'(i_cfg.length_limit);

    // Window fill and sync detection
    assign w_since_inc = r_since[3] ? r_since : r_since + 4'd1;
    assign w_full      = w_since_inc[3];
    assign w_match     = i_match && !r_sig_bad && w_full;
    assign w_sig_bad1  = r_sig_bad || (w_full && !i_match && !r_open);

    // Close on a sync word
    assign w_p1         = r_pos + PW'(1);
    assign w_sync_start = r_pos - PW'(7);
    assign w_len1       = w_sync_start - r_start;
    assign w_close1     = w_match && r_open;
    assign w_emit1      = w_close1 && (r_blocks < w_lim_x);
    assign w_blocks1    = (w_close1 && (r_blocks <= w_lim_x)) ? r_blocks + CntW'(1)
                                                              : r_blocks;
    assign w_too_long1  = r_too_long || (w_emit1 && (w_len1 > w_llim));
    assign w_content1   = r_content || (w_emit1 && (w_len1 != '0));
    assign w_open1      = r_open || w_match;
    assign w_start1     = w_match ? w_p1 : r_start;

    // Close on the final byte
    assign w_len2      = w_p1 - w_start1;
    assign w_close2    = i_final && w_open1;
    assign w_emit2     = w_close2 && (w_blocks1 < w_lim_x);
    assign w_blocks2   = (w_close2 && (w_blocks1 <= w_lim_x)) ? w_blocks1 + CntW'(1)
                                                              : w_blocks1;
    assign w_too_long2 = w_too_long1 || (w_emit2 && (w_len2 > w_llim));
    assign w_content2  = w_content1 || (w_emit2 && (w_len2 != '0));
    assign w_sig_bad2  = w_sig_bad1 || (i_final && !w_open1);

    // Pick the final status by priority
    always_comb begin
        priority if (w_sig_bad2) begin
            w_status = swbs_pkg::ST_BAD_SIG;
        end else if (w_blocks2 > w_lim_x) begin
            w_status = swbs_pkg::ST_TOO_MANY;
        end else if (w_too_long2) begin
            w_status = swbs_pkg::ST_TOO_LONG;
        end else if (!w_content2) begin
            w_status = swbs_pkg::ST_NO_CONTENT;
        end else begin
            w_status = swbs_pkg::ST_OK;
        end
    end

    // Candidate result beats
    always_comb begin
        w_r1                = '0;
        w_r1.has_block      = 1'b1;
        w_r1.block_number   = r_blocks[7:0];
        w_r1.payload_offset = 32'(r_start);
        w_r1.payload_length = 32'(w_len1);

        w_r2                = '0;
        w_r2.has_block      = 1'b1;
        w_r2.block_number   = w_blocks1[7:0];
        w_r2.payload_offset = 32'(w_start1);
        w_r2.payload_length = 32'(w_len2);

        w_empty             = '0;
    end

    // Order the beats and mark the last one of the stream
    always_comb begin
        o_res_a = w_emit1 ? w_r1 : (w_emit2 ? w_r2 : w_empty);
        o_res_b = w_r2;
        if (w_emit1 && w_emit2) begin
            o_push_cnt = 2'd2;
        end else if (w_emit1 || w_emit2 || i_final) begin
            o_push_cnt = 2'd1;
        end else begin
            o_push_cnt = 2'd0;
        end

        if (i_final) begin
            if (w_emit1 && w_emit2) begin
                o_res_b.final_status = w_status;
                o_res_b.run_end      = 1'b1;
            end else begin
                o_res_a.final_status = w_status;
                o_res_a.run_end      = 1'b1;
            end
        end
    end

    // Update state per beat; clear everything after the final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_start    <= '0;
            r_since    <= '0;
            r_open     <= 1'b0;
            r_blocks   <= '0;
            r_content  <= 1'b0;
            r_too_long <= 1'b0;
            r_sig_bad  <= 1'b0;
        end else if (i_accept) begin
            if (i_final) begin
                r_pos      <= '0;
                r_start    <= '0;
                r_since    <= '0;
                r_open     <= 1'b0;
                r_blocks   <= '0;
                r_content  <= 1'b0;
                r_too_long <= 1'b0;
                r_sig_bad  <= 1'b0;
            end else begin
                r_pos      <= w_p1;
                r_start    <= w_start1;
                r_since    <= w_match ? 4'd0 : w_since_inc;
                r_open     <= w_open1;
                r_blocks   <= w_blocks1;
                r_content  <= w_content1;
                r_too_long <= w_too_long1;
                r_sig_bad  <= w_sig_bad1;
            end
        end
    end

endmodule

[sv/swbs_fifo.sv]
// ----------------------------------------------------------------------------
// swbs_fifo: result queue
// Takes up to two result beats per cycle and delivers one per cycle while the reader pops.
// The writer must only push when two slots are free.
// ----------------------------------------------------------------------------
module swbs_fifo (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [1:0]                          i_push_cnt,
    input  swbs_pkg::t_result                   i_data_a,
    input  swbs_pkg::t_result                   i_data_b,
    input  logic                                i_pop,
    output swbs_pkg::t_result                   o_data,
    output logic                                o_valid,
    output logic [swbs_pkg::LEVEL_W-1:0]        o_level
);

    localparam int Depth = swbs_pkg::FIFO_DEPTH;
    localparam int AW    = swbs_pkg::FIFO_AW;
    localparam int LW    = swbs_pkg::LEVEL_W;

    swbs_pkg::t_result r_mem [Depth];
    logic [AW-1:0]     r_wr;
    logic [AW-1:0]     r_rd;
    logic [LW-1:0]     r_level;
    logic [AW-1:0]     w_wr1;
    logic              w_pop;

    assign w_wr1 = r_wr + AW'(1);
    assign w_pop = i_pop && (r_level != '0);

    // Store pushed beats
    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr] <= i_data_a;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[w_wr1] <= i_data_b;
        end
    end

    // Advance pointers and level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            r_wr    <= r_wr + AW'(i_push_cnt);
            r_rd    <= r_rd + AW'(w_pop);
            r_level <= r_level + LW'(i_push_cnt) - LW'(w_pop);
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_valid = (r_level != '0);
    assign o_level = r_level;

endmodule

[sv/sync_word_block_splitter.sv]
// ----------------------------------------------------------------------------
// sync_word_block_splitter: cut a byte stream into blocks at a sync word
// Top level: configuration registers, sync window, tracker, result queue.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) carries one image byte per beat with
//   i_final_byte set on the last byte. Output channel (o_valid / i_stall)
//   carries result beats: one per closed block under the block limit; the
//   last beat of a stream has o_run_end set and the stream's final status.
//   A byte may produce zero, one or two result beats.
//   A result beat is written into the result queue when its byte is accepted.
//   Throughput: one byte per cycle while o_stall is low; the window compare
//   and the block counters finish in that cycle. The four-entry result queue
//   raises o_stall while fewer than two entries are free, so a stalled
//   receiver backs up into the input channel once more than two beats wait.
//   Reset (synchronous, active low) loads the register defaults, empties
//   the result queue and starts a new stream. After the final byte all
//   stream state clears and the next byte starts a new stream.
//   Registers sit at byte addresses 0 (sync word, 64 bits), 8 (block
//   limit) and 16 (length limit); write them only while the block is idle.
// ----------------------------------------------------------------------------
module sync_word_block_splitter #(
    parameter int POSITION_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Byte input
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_final_byte,
    // Result output
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_has_block,
    output logic [7:0]  o_block_number,
    output logic [31:0] o_payload_offset,
    output logic [31:0] o_payload_length,
    output logic [2:0]  o_final_status,
    output logic        o_run_end,
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int LW        = swbs_pkg::LEVEL_W;
    localparam int StallMark = swbs_pkg::FIFO_DEPTH - 2;

    swbs_pkg::t_cfg    r_cfg;
    swbs_pkg::t_result w_res_a;
    swbs_pkg::t_result w_res_b;
    swbs_pkg::t_result w_out;
    logic [1:0]        w_push_cnt;
    logic [1:0]        w_push;
    logic [LW-1:0]     w_level;
    logic              w_in_acc;
    logic              w_out_acc;
    logic              w_match;
    logic              w_cfg_wr;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign o_stall   = (w_level > LW'(StallMark));
    assign w_in_acc  = i_valid && !o_stall;
    assign w_out_acc = o_valid && !i_stall;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_pattern <= swbs_pkg::SYNC_RESET;
            r_cfg.block_limit  <= swbs_pkg::BLIMIT_RESET;
            r_cfg.length_limit <= swbs_pkg::LLIMIT_RESET;
        end else if (w_cfg_wr) begin
            unique case (paddr[4:3])
                swbs_pkg::REG_SYNC:         r_cfg.sync_pattern <= pwdata;
                swbs_pkg::REG_BLOCK_LIMIT:  r_cfg.block_limit  <= pwdata[8:0];
                swbs_pkg::REG_LENGTH_LIMIT: r_cfg.length_limit <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // Read back configuration registers
    always_comb begin
        unique case (paddr[4:3])
            swbs_pkg::REG_SYNC:         prdata = r_cfg.sync_pattern;
            swbs_pkg::REG_BLOCK_LIMIT:  prdata = 64'(r_cfg.block_limit);
            swbs_pkg::REG_LENGTH_LIMIT: prdata = 64'(r_cfg.length_limit);
            default:                    prdata = '0;
        endcase
    end

    swbs_window u_window (
        .i_clk     (i_clk),
        .i_shift   (w_in_acc),
        .i_byte    (i_data_byte),
        .i_pattern (r_cfg.sync_pattern),
        .o_match   (w_match)
    );

    swbs_tracker #(
        .POSITION_BITS (POSITION_BITS)
    ) u_tracker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_in_acc),
        .i_final    (i_final_byte),
        .i_match    (w_match),
        .i_cfg      (r_cfg),
        .o_res_a    (w_res_a),
        .o_res_b    (w_res_b),
        .o_push_cnt (w_push_cnt)
    );

    // Push only on accepted beats
    assign w_push = w_in_acc ? w_push_cnt : 2'd0;

    swbs_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (w_push),
        .i_data_a   (w_res_a),
        .i_data_b   (w_res_b),
        .i_pop      (w_out_acc),
        .o_data     (w_out),
        .o_valid    (o_valid),
        .o_level    (w_level)
    );

    assign o_has_block      = w_out.has_block;
    assign o_block_number   = w_out.block_number;
    assign o_payload_offset = w_out.payload_offset;
    assign o_payload_length = w_out.payload_length;
    assign o_final_status   = w_out.final_status;
    assign o_run_end        = w_out.run_end;

    // Queue never overfills
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_level <= LW'(swbs_pkg::FIFO_DEPTH))
        else $error("result queue overflow");

    // A beat without a block is only the closing beat of a stream
    a_empty_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_has_block) |-> o_run_end)
        else $error("empty result beat that does not end the stream");

    // Beats before the stream end carry no status
    a_mid_status_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_run_end) |-> (o_final_status == swbs_pkg::ST_OK))
        else $error("status on a non-final result beat");

    // Level grows by at most two beats per cycle
    a_level_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> ({1'b0, w_level} <= {1'b0, $past(w_level)} + (LW+1)'(2)))
        else $error("result queue grew by more than two beats");

endmodule

[sim/tb_sync_word_block_splitter.sv]
// ----------------------------------------------------------------------------
// tb_sync_word_block_splitter: self-checking bench for the sync-word splitter
// Feeds tape images (well-formed sync/payload trains, noise, short and
// corrupted streams) under several register settings, predicts every result
// beat in a scoreboard class and checks each beat field by field.
// ----------------------------------------------------------------------------
module tb_sync_word_block_splitter;

    // Track stream state and hold the result beats still owed by the block
    class split_scoreboard;
        logic [63:0] sync_word;
        logic [8:0]  block_cap;
        logic [15:0] len_cap;
        logic [63:0] window;
        logic [31:0] position;
        logic [31:0] open_start;
        logic [3:0]  since_sync;
        logic        in_block;
        logic [9:0]  blk_total;
        logic        saw_content;
        logic        saw_too_long;
        logic        bad_sig;
        swbs_pkg::t_result step_buf[2];
        int          step_n;
        swbs_pkg::t_result expected_beats[$];
        int          errors;
        int          beats_checked;

        function new();
            sync_word     = swbs_pkg::SYNC_RESET;
            block_cap     = swbs_pkg::BLIMIT_RESET;
            len_cap       = swbs_pkg::LLIMIT_RESET;
            errors        = 0;
            beats_checked = 0;
            clear_run();
        endfunction

        function void clear_run();
            window       = '0;
            position     = '0;
            open_start   = '0;
            since_sync   = '0;
            in_block     = 1'b0;
            blk_total    = '0;
            saw_content  = 1'b0;
            saw_too_long = 1'b0;
            bad_sig      = 1'b0;
        endfunction

        function void set_register(logic [1:0] idx, logic [63:0] value);
            case (idx)
                swbs_pkg::REG_SYNC:         sync_word = value;
                swbs_pkg::REG_BLOCK_LIMIT:  block_cap = value[8:0];
                swbs_pkg::REG_LENGTH_LIMIT: len_cap   = value[15:0];
                default: ;
            endcase
        endfunction

        // Effective block limit: the register, capped by the build limit
        function int block_ceiling();
            int lim;
            lim = block_cap;
            if (lim > swbs_pkg::MOST_BLOCKS) lim = swbs_pkg::MOST_BLOCKS;
            return lim;
        endfunction

        // Count a closed block; emit it only while under the limit
        function void close_block(logic [31:0] start, logic [31:0] len);
            swbs_pkg::t_result r;
            int      lim;
            lim = block_ceiling();
            if (blk_total < lim) begin
                if (len > len_cap) saw_too_long = 1'b1;
                if (len != 0) saw_content = 1'b1;
                r = '0;
                r.has_block      = 1'b1;
                r.block_number   = blk_total[7:0];
                r.payload_offset = start;
                r.payload_length = len;
                r.final_status   = swbs_pkg::ST_OK;
                step_buf[step_n] = r;
                step_n++;
            end
            if (blk_total <= lim) blk_total++;
        endfunction

        // Advance the stream by one accepted byte and queue its result beats
        function void take_byte(logic [7:0] b, logic last);
            logic [31:0] p;
            logic        hit;
            logic [2:0]  status;
            p      = position;
            hit    = 1'b0;
            step_n = 0;
            window = {window[55:0], b};
            if (since_sync < 4'd8) since_sync++;

            if (!bad_sig && since_sync >= 4'd8) begin
                if (window == sync_word) hit = 1'b1;
                else if (!in_block) bad_sig = 1'b1;
            end

            // Sync word found: close the open block, open the next one
            if (hit) begin
                if (in_block) close_block(open_start, (p - 32'd7) - open_start);
                in_block   = 1'b1;
                open_start = p + 32'd1;
                since_sync = '0;
            end
            position = p + 32'd1;

            // Last byte: close what is open, fold in the run status, restart
            if (last) begin
                if (!in_block) bad_sig = 1'b1;
                else close_block(open_start, p + 32'd1 - open_start);

                if (bad_sig) status = swbs_pkg::ST_BAD_SIG;
                else if (blk_total > block_ceiling()) status = swbs_pkg::ST_TOO_MANY;
                else if (saw_too_long) status = swbs_pkg::ST_TOO_LONG;
                else if (!saw_content) status = swbs_pkg::ST_NO_CONTENT;
                else status = swbs_pkg::ST_OK;

                if (step_n == 0) begin
                    step_buf[0] = '0;
                    step_n = 1;
                end
                step_buf[step_n-1].final_status = status;
                step_buf[step_n-1].run_end      = 1'b1;
                clear_run();
            end

            for (int k = 0; k < step_n; k++) expected_beats.push_back(step_buf[k]);
        endfunction

        // Compare one accepted beat against the oldest expectation
        function void check_beat(swbs_pkg::t_result got);
            swbs_pkg::t_result want;
            beats_checked++;
            if (expected_beats.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected beat: has=%0d num=%0d off=%0d len=%0d st=%0d end=%0d",
                             got.has_block, got.block_number, got.payload_offset,
                             got.payload_length, got.final_status, got.run_end);
                return;
            end
            want = expected_beats.pop_front();
            if (got.has_block !== want.has_block ||
                got.block_number !== want.block_number ||
                got.payload_offset !== want.payload_offset ||
                got.payload_length !== want.payload_length ||
                got.final_status !== want.final_status ||
                got.run_end !== want.run_end) begin
                errors++;
                if (errors <= 10) begin
                    $display({"beat mismatch: expected has=%0d num=%0d off=%0d",
                              " len=%0d st=%0d end=%0d"},
                             want.has_block, want.block_number, want.payload_offset,
                             want.payload_length, want.final_status, want.run_end);
                    $display({"               actual   has=%0d num=%0d off=%0d",
                              " len=%0d st=%0d end=%0d"},
                             got.has_block, got.block_number, got.payload_offset,
                             got.payload_length, got.final_status, got.run_end);
                end
            end
        endfunction
    endclass

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic        o_stall;
    logic [7:0]  i_data_byte  = '0;
    logic        i_final_byte = 1'b0;
    logic        o_valid;
    logic        i_stall      = 1'b0;
    logic        o_has_block;
    logic [7:0]  o_block_number;
    logic [31:0] o_payload_offset;
    logic [31:0] o_payload_length;
    logic [2:0]  o_final_status;
    logic        o_run_end;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [4:0]  paddr        = '0;
    logic [63:0] pwdata       = '0;
    logic [63:0] prdata;
    logic        pready;

    split_scoreboard sb;
    logic [7:0]      image[$];
    int              tx_idle_pct   = 17;
    int              rx_idle_pct   = 86;
    int              hold_left     = 0;
    bit              hold_request  = 1'b0;
    int              bytes_sent    = 0;
    int              streams_sent  = 0;
    int              settings_used = 0;
    int              random_bytes  = 0;

    sync_word_block_splitter dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_data_byte      (i_data_byte),
        .i_final_byte     (i_final_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_has_block      (o_has_block),
        .o_block_number   (o_block_number),
        .o_payload_offset (o_payload_offset),
        .o_payload_length (o_payload_length),
        .o_final_status   (o_final_status),
        .o_run_end        (o_run_end),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // Free-running clock, period 10
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Give up after a generous bound
    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Result side: check accepted beats, then pick the next stall value
    initial begin
        forever begin
            @(posedge i_clk);
            if (o_valid === 1'b1 && i_stall == 1'b0)
                sb.check_beat({o_has_block, o_block_number, o_payload_offset,
                               o_payload_length, o_final_status, o_run_end});
            if (hold_request) begin
                hold_left    = 300;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(0, 99) < rx_idle_pct);
            end
        end
    end

    // Write one register through a setup phase and then an access phase
    task automatic write_register(input logic [1:0] idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        sb.set_register(idx, value);
    endtask

    task automatic write_settings(input logic [63:0] sync_value, input logic [8:0] blimit,
                                  input logic [15:0] llimit);
        write_register(swbs_pkg::REG_SYNC, sync_value);
        write_register(swbs_pkg::REG_BLOCK_LIMIT, {55'd0, blimit});
        write_register(swbs_pkg::REG_LENGTH_LIMIT, {48'd0, llimit});
        settings_used++;
    endtask

    // Offer one beat, idling at random first, and hold it until accepted
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_data_byte  <= b;
        i_final_byte <= last;
        do begin
            @(posedge i_clk);
        end while (o_stall !== 1'b0);
        sb.take_byte(b, last);
        bytes_sent++;
    endtask

    // Drop valid, then wait for every owed beat and idle for slack
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.expected_beats.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic send_image();
        for (int j = 0; j < image.size(); j++) send_byte(image[j], j == image.size() - 1);
        streams_sent++;
    endtask

    // Payload byte: often a byte of the sync word, to provoke near matches
    function automatic logic [7:0] payload_byte();
        if ($urandom_range(0, 2) == 0) return sb.sync_word[8*$urandom_range(0, 7) +: 8];
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void push_sync();
        for (int k = 7; k >= 0; k--) image.push_back(sb.sync_word[8*k +: 8]);
    endfunction

    // Send a train of sync words, each followed by plen payload bytes
    task automatic play_block_train(input int count, input int plen);
        image.delete();
        for (int k = 0; k < count; k++) begin
            push_sync();
            for (int j = 0; j < plen; j++) image.push_back(payload_byte());
        end
        send_image();
    endtask

    // Mostly well-formed streams with random content; the rest broken
    task automatic play_stream();
        int kind;
        int nblk;
        int plen;
        int pos;
        kind = $urandom_range(0, 9);
        image.delete();
        if (kind <= 6) begin
            nblk = $urandom_range(1, 4);
            for (int k = 0; k < nblk; k++) begin
                push_sync();
                plen = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 40)
                                                   : $urandom_range(0, 12);
                // End some streams right on a sync word
                if (k == nblk - 1 && $urandom_range(0, 4) == 0) plen = 0;
                for (int j = 0; j < plen; j++) image.push_back(payload_byte());
            end
        end else if (kind == 7) begin
            plen = $urandom_range(1, 20);
            for (int j = 0; j < plen; j++) image.push_back(8'($urandom_range(0, 255)));
        end else if (kind == 8) begin
            // Corrupt the opening sync word; a later good one must be ignored
            push_sync();
            pos = $urandom_range(0, 7);
            image[pos] = image[pos] ^ (8'd1 << $urandom_range(0, 7));
            plen = $urandom_range(0, 6);
            for (int j = 0; j < plen; j++) image.push_back(payload_byte());
            push_sync();
            plen = $urandom_range(0, 6);
            for (int j = 0; j < plen; j++) image.push_back(payload_byte());
        end else begin
            // Short stream: a prefix of the sync word only
            plen = $urandom_range(1, 7);
            for (int k = 7; k > 7 - plen; k--) image.push_back(sb.sync_word[8*k +: 8]);
        end
        random_bytes += image.size();
        send_image();
    endtask

    // Main sequence
    initial begin
        int phase;
        int phase_start;
        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: short stream with byte extremes, lone final byte,
        // one block with payload, sync word right at the stream end
        image.delete();
        image.push_back(8'h00);
        image.push_back(8'hFF);
        image.push_back(8'h5A);
        send_image();
        image.delete();
        image.push_back(8'h80);
        send_image();
        play_block_train(1, 2);
        play_block_train(1, 0);
        drain();

        // Random phases, each under its own register setting
        phase = 0;
        while (random_bytes < 260) begin
            case (phase)
                0: write_settings(swbs_pkg::SYNC_RESET, swbs_pkg::BLIMIT_RESET,
                                  swbs_pkg::LLIMIT_RESET);
                1: write_settings(64'hFFFF_FFFF_FFFF_FFFF, 9'd16, 16'd1);
                2: write_settings(64'h0, 9'd3, 16'd4);
                3: write_settings(64'hAAAA_AAAA_AAAA_AAAA, 9'd2, 16'd8);
                4: write_settings({$urandom, $urandom}, 9'd511, 16'd65535);
                5: write_settings({$urandom, $urandom}, 9'd0, 16'd10);
                default: write_settings({$urandom, $urandom}, 9'($urandom_range(1, 256)),
                                        ($urandom_range(0, 3) == 0)
                                            ? 16'd65535
                                            : 16'($urandom_range(1, 24)));
            endcase

            // Hold the receiver off while the sender keeps offering beats
            if (phase == 1) begin
                tx_idle_pct  = 17;
                rx_idle_pct  = 86;
                hold_request = 1'b1;
                play_block_train(12, 2);
            end

            phase_start = random_bytes;
            while (random_bytes - phase_start < 40) begin
                if (random_bytes < 90) begin
                    tx_idle_pct = 17;
                    rx_idle_pct = 86;
                end else if (random_bytes < 180) begin
                    tx_idle_pct = 86;
                    rx_idle_pct = 17;
                end else begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
                play_stream();
            end
            drain();
            phase++;
        end

        // Run past the block limit with back-to-back sync words
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_settings(swbs_pkg::SYNC_RESET, 9'd4, swbs_pkg::LLIMIT_RESET);
        play_block_train(6, 0);
        drain();

        $display("Run covered %0d bytes in %0d streams under %0d register settings;",
                 bytes_sent, streams_sent, settings_used);
        $display("%0d result beats checked, with a long receiver hold and a limit overrun.",
                 sb.beats_checked);
        if (sb.errors == 0 && sb.expected_beats.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
sv/swbs_pkg.sv
sv/swbs_cell.sv
sv/swbs_window.sv
sv/swbs_tracker.sv
sv/swbs_fifo.sv
sv/sync_word_block_splitter.sv
sim/tb_sync_word_block_splitter.sv
